// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the deadline-sorted task queue.
// Used by the top level; clocked, with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dstq_pkg.sv =====
// Shared types and constants for the deadline-sorted task queue.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package dstq_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int PERIODIC_LEVEL_DEF = 1;

    localparam int OP_W    = 2;
    localparam int ID_W    = 8;
    localparam int LEVEL_W = 2;
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 5;

    // request codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd3;

    // APB register byte addresses
    localparam logic [2:0] ADDR_QUEUE_LEVEL = 3'd0;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture incoming request
        logic cmp;    // register per-cell compare results
        logic apply;  // update cells, fill and result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;  // result register occupied and not being taken
    } t_stat;

endpackage

// ===== rtl/dstq_ctrl.sv =====
// Request sequencer for the deadline-sorted task queue.
// Depends on dstq_pkg (t_cmd, t_stat).
`timescale 1ns / 1ps

module dstq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dstq_pkg::t_stat i_stat,
    output dstq_pkg::t_cmd  o_cmd
);
    import dstq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                // next request may be captured on the same edge as the update
                if (!i_stat.out_full) begin
                    o_cmd.apply = 1'b1;
                    o_in_ready  = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dstq_datapath.sv =====
// Cell chain, request register and result register of the task queue.
// Depends on dstq_pkg (t_cmd, t_stat, op codes, widths).
`timescale 1ns / 1ps

module dstq_datapath #(
    parameter int DEPTH    = dstq_pkg::QUEUE_DEPTH_DEF,
    parameter int PERIODIC = dstq_pkg::PERIODIC_LEVEL_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dstq_pkg::t_cmd                i_cmd,
    output dstq_pkg::t_stat               o_stat,
    input  logic [dstq_pkg::OP_W-1:0]     i_op,
    input  logic [dstq_pkg::ID_W-1:0]     i_id,
    input  logic [dstq_pkg::LEVEL_W-1:0]  i_level,
    input  logic [dstq_pkg::TIME_W-1:0]   i_time,
    input  logic                          i_epoch,
    input  logic [dstq_pkg::LEVEL_W-1:0]  i_queue_level,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_res_valid,
    output logic [dstq_pkg::ID_W-1:0]     o_res_id,
    output logic [dstq_pkg::TIME_W-1:0]   o_res_time,
    output logic                          o_res_epoch,
    output logic                          o_res_error,
    output logic [dstq_pkg::COUNT_W-1:0]  o_res_count
);
    import dstq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [DEPTH-1:0] ONES = '1;

    // request register
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_id;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_time;
    logic               r_epoch;

    // cells, slot 0 is the head
    logic [ID_W-1:0]    r_cid   [DEPTH];
    logic [TIME_W-1:0]  r_ctime [DEPTH];
    logic               r_cepoch[DEPTH];
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      n_fill;
    logic [DEPTH-1:0]   r_stop;
    logic [DEPTH-1:0]   n_stop;

    // result register
    logic               r_out_valid;
    logic               r_res_valid;
    logic [ID_W-1:0]    r_res_id;
    logic [TIME_W-1:0]  r_res_time;
    logic               r_res_epoch;
    logic               r_res_error;
    logic [COUNT_W-1:0] r_res_count;

    logic [DEPTH-1:0]   hit;
    logic [DEPTH-1:0]   ge;
    logic [DEPTH-1:0]   ge_prev;
    logic               full;
    logic               empty;
    logic               level_ok;
    logic               periodic_ok;
    logic               err;
    logic               valid;
    logic               do_app;
    logic               do_ins;
    logic               do_deq;
    logic [31:0]        n_fill32;

    // new task (t, e) starts after queued task (st, se)
    function automatic logic starts_later(
        input logic [TIME_W-1:0] t,
        input logic              e,
        input logic [TIME_W-1:0] st,
        input logic              se
    );
        logic res;
        if (e != se) begin
            res = (t < st);
        end else begin
            res = (t > st);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_id    <= i_id;
            r_level <= i_level;
            r_time  <= i_time;
            r_epoch <= i_epoch;
        end
    end

    // cell k stops the insert when it holds a task not earlier than the new one
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_stop[k] = (CW'(k) < r_fill) &&
                        !starts_later(r_time, r_epoch, r_ctime[k], r_cepoch[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_stop <= n_stop;
        end
    end

    // ge[k]: insert position is at or below k
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            hit[k] = r_stop[k] | (CW'(k) == r_fill);
        end
        for (int k = 0; k < DEPTH; k++) begin
            ge[k] = |(hit & (ONES >> (DEPTH - 1 - k)));
        end
        ge_prev = {ge[DEPTH-2:0], 1'b0};
    end

    assign full        = (r_fill == CW'(DEPTH));
    assign empty       = (r_fill == '0);
    assign level_ok    = (r_level == i_queue_level);
    assign periodic_ok = (i_queue_level == LEVEL_W'(PERIODIC));

    always_comb begin
        err    = 1'b0;
        valid  = 1'b0;
        do_app = 1'b0;
        do_ins = 1'b0;
        do_deq = 1'b0;
        n_fill = r_fill;
        case (r_op)
            OP_APPEND: begin
                err    = !level_ok || full;
                do_app = !err;
            end
            OP_INSERT: begin
                err    = !level_ok || !periodic_ok || full;
                do_ins = !err;
            end
            OP_DEQUEUE: begin
                err    = empty;
                do_deq = !err;
                valid  = !err;
            end
            default: begin
                valid = !empty;
            end
        endcase
        if (do_app || do_ins) begin
            n_fill = r_fill + CW'(1);
        end else if (do_deq) begin
            n_fill = r_fill - CW'(1);
        end
        n_fill32 = 32'(n_fill);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.apply) begin
                if ((do_app && (CW'(g) == r_fill)) ||
                    (do_ins && ge[g] && !ge_prev[g])) begin
                    r_cid[g]    <= r_id;
                    r_ctime[g]  <= r_time;
                    r_cepoch[g] <= r_epoch;
                end else if (do_ins && ge_prev[g]) begin
                    if (g > 0) begin
                        r_cid[g]    <= r_cid[(g > 0) ? g - 1 : 0];
                        r_ctime[g]  <= r_ctime[(g > 0) ? g - 1 : 0];
                        r_cepoch[g] <= r_cepoch[(g > 0) ? g - 1 : 0];
                    end
                end else if (do_deq && (g < DEPTH - 1)) begin
                    r_cid[g]    <= r_cid[(g < DEPTH - 1) ? g + 1 : g];
                    r_ctime[g]  <= r_ctime[(g < DEPTH - 1) ? g + 1 : g];
                    r_cepoch[g] <= r_cepoch[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res_valid <= valid;
            r_res_id    <= valid ? r_cid[0] : '0;
            r_res_time  <= valid ? r_ctime[0] : '0;
            r_res_epoch <= valid ? r_cepoch[0] : 1'b0;
            r_res_error <= err;
            r_res_count <= n_fill32[COUNT_W-1:0];
        end
    end

    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_res_valid     = r_res_valid;
    assign o_res_id        = r_res_id;
    assign o_res_time      = r_res_time;
    assign o_res_epoch     = r_res_epoch;
    assign o_res_error     = r_res_error;
    assign o_res_count     = r_res_count;

endmodule

// ===== rtl/deadline_sorted_task_queue.sv =====
// Top level of the deadline-sorted task queue: stream ports, APB register.
// Depends on dstq_pkg, dstq_ctrl, dstq_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// - s_axis carries one request per transfer: tuser selects append, sorted
//   insert, dequeue or peek; tdata carries the task. Every request gives
//   exactly one result on m_axis (task or empty flag, error flag, count).
// - The queue is a chain of QUEUE_DEPTH cells, slot 0 the head. A sorted
//   insert compares every cell with the new task in parallel, registers the
//   compare bits, then shifts the tail up by one; dequeue shifts down.
// - Steps: the request is registered on acceptance, the compare step
//   registers the compare bits, then the apply step writes the result register.
// - Requests are taken one at a time, paced by the compare/apply pair;
//   s_axis_tready is high again in the apply cycle unless the result register is still held.
// - Stall: the result register holds until m_axis_tready. One new request
//   may be taken meanwhile; its apply waits until the result is taken.
// - Reset (synchronous, i_rst_n low) empties the queue and sets
//   queue_level to 0. No clearing pass: cells are only read below fill.
// - queue_level sits at byte address 0 of the APB port; write it only while
//   no request is in flight. Changing it keeps the queued tasks.
module deadline_sorted_task_queue #(
    parameter int QUEUE_DEPTH    = dstq_pkg::QUEUE_DEPTH_DEF,
    parameter int PERIODIC_LEVEL = dstq_pkg::PERIODIC_LEVEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // task_id[7:0], task_level[9:8],
                                        // task_time[25:10], task_epoch[26], zero
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_id[7:0], out_time[23:8],
                                        // out_epoch[24], count[29:25], zero
    output logic [1:0]  m_axis_tuser,   // out_valid[0], error[1]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dstq_pkg::*;

    logic [LEVEL_W-1:0] r_queue_level;

    t_cmd               cmd;
    t_stat              stat;

    logic               res_valid;
    logic [ID_W-1:0]    res_id;
    logic [TIME_W-1:0]  res_time;
    logic               res_epoch;
    logic               res_error;
    logic [COUNT_W-1:0] res_count;

    // APB register: written in the access phase, no wait states
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_level <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == ADDR_QUEUE_LEVEL)) begin
            r_queue_level <= pwdata[LEVEL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_QUEUE_LEVEL) begin
            prdata = {{(32 - LEVEL_W){1'b0}}, r_queue_level};
        end
    end

    dstq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dstq_datapath #(
        .DEPTH    (QUEUE_DEPTH),
        .PERIODIC (PERIODIC_LEVEL)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (s_axis_tuser[OP_W-1:0]),
        .i_id          (s_axis_tdata[7:0]),
        .i_level       (s_axis_tdata[9:8]),
        .i_time        (s_axis_tdata[25:10]),
        .i_epoch       (s_axis_tdata[26]),
        .i_queue_level (r_queue_level),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_res_valid   (res_valid),
        .o_res_id      (res_id),
        .o_res_time    (res_time),
        .o_res_epoch   (res_epoch),
        .o_res_error   (res_error),
        .o_res_count   (res_count)
    );

    assign m_axis_tdata = {2'b00, res_count, res_epoch, res_time, res_id};
    assign m_axis_tuser = {res_error, res_valid};

    // a returned task and a rejection never come together
    `ASSERT_NEVER(a_valid_and_error, i_clk, i_rst_n,
                  m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1],
                  "result both valid and error")

    // after taking a request the block is busy comparing
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n,
                s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
                "request accepted during compare")

    // a result appears only from an apply step
    `ASSERT_CLK(a_result_from_apply, i_clk, i_rst_n,
                $rose(m_axis_tvalid) |-> $past(cmd.apply),
                "result without apply")

endmodule
